// ===== hw/rtl/hmq_pkg.sv =====
// shared types and constants of the binary min-heap queue
package hmq_pkg;

  // heap geometry and field widths
  localparam int unsigned HEAP_DEPTH = 64;
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CHILD_W    = ADDR_W + 2;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CHANGE  = 2'd2,
    OP_DELETE  = 2'd3
  } hmq_op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } hmq_status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXT_RD,
    S_EXT_USE,
    S_CHG_RD,
    S_CHG_USE,
    S_DEL_RD1,
    S_DEL_RD2,
    S_DEL_USE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } hmq_state_e;

  // one access to the key store: one write and one read per cycle
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0]  wr_data;
    logic [ADDR_W-1:0]        rd_addr;
  } hmq_mem_req_t;

endpackage

// ===== hw/rtl/hmq_store.sv =====
// key store of the heap with a mirrored root register
module hmq_store (
  input  logic                              clk_i,
  input  hmq_pkg::hmq_mem_req_t             req_i,
  output logic signed [hmq_pkg::KEY_W-1:0]  rd_data_o,
  output logic signed [hmq_pkg::KEY_W-1:0]  root_o
);

  logic signed [hmq_pkg::KEY_W-1:0] mem_q [hmq_pkg::HEAP_DEPTH];
  logic signed [hmq_pkg::KEY_W-1:0] rd_data_q;
  logic signed [hmq_pkg::KEY_W-1:0] root_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[req_i.rd_addr];
  end

  // copy of slot zero so the minimum needs no read
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.wr_addr == '0)) begin
      root_q <= req_i.wr_data;
    end
  end

  assign rd_data_o = rd_data_q;
  assign root_o    = root_q;

endmodule

// ===== hw/rtl/binary_min_heap_queue.sv =====
// binary min-heap priority queue: sequencer, shared comparator and key store
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, opcode_i, key_value_i,   | to block
//           | entry_index_i                                   |
//   out     | out_valid_o, out_ready_i, status_o,              | from block
//           | extracted_key_o, min_key_o, entry_count_o       |
//
// insert: each parent is read, then compared; the key is written where it stops or at the root
// extract: reads the last key, then per slot with children reads each child and compares
// change reads the old key, delete the old key and then the last key; then a walk up or down
// then the done state presents the result, held until out_ready_i; ready only while idle
// refused items, an extract of the last key and a delete of the last slot skip the walk
// reset clears the count and the sequencer; store contents need no clearing
module binary_min_heap_queue (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [hmq_pkg::OP_W-1:0]             opcode_i,
  input  logic signed [hmq_pkg::KEY_W-1:0]     key_value_i,
  input  logic [hmq_pkg::ADDR_W-1:0]           entry_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [hmq_pkg::STATUS_W-1:0]         status_o,
  output logic signed [hmq_pkg::KEY_W-1:0]     extracted_key_o,
  output logic signed [hmq_pkg::KEY_W-1:0]     min_key_o,
  output logic [hmq_pkg::CNT_W-1:0]            entry_count_o
);

  hmq_pkg::hmq_state_e                state_q, state_d;
  logic [hmq_pkg::CNT_W-1:0]          count_q, count_d;
  logic [hmq_pkg::ADDR_W-1:0]         pos_q, pos_d;
  logic [hmq_pkg::ADDR_W-1:0]         idx_q, idx_d;
  logic [hmq_pkg::ADDR_W-1:0]         child_pos_q, child_pos_d;
  logic signed [hmq_pkg::KEY_W-1:0]   key_q, key_d;
  logic signed [hmq_pkg::KEY_W-1:0]   child_q, child_d;
  logic signed [hmq_pkg::KEY_W-1:0]   old_q, old_d;
  logic signed [hmq_pkg::KEY_W-1:0]   extracted_q, extracted_d;
  hmq_pkg::hmq_status_e               status_q, status_d;

  hmq_pkg::hmq_mem_req_t              mem_req;
  logic signed [hmq_pkg::KEY_W-1:0]   rd_data;
  logic signed [hmq_pkg::KEY_W-1:0]   root_key;

  logic signed [hmq_pkg::KEY_W-1:0]   cmp_a, cmp_b;
  logic                               cmp_lt;

  logic                               accept;
  hmq_pkg::hmq_op_e                   op_in;
  logic                               idx_ok;
  logic                               del_last;
  logic                               is_full;
  logic                               is_empty;
  logic [hmq_pkg::ADDR_W-1:0]         parent_pos;
  logic [hmq_pkg::CHILD_W-1:0]        left_pos, right_pos, count_ext;
  logic                               has_left, has_right;

  // key store
  hmq_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data),
    .root_o    (root_key)
  );

  // item decode and heap index arithmetic
  assign accept     = in_valid_i && in_ready_o;
  assign op_in      = hmq_pkg::hmq_op_e'(opcode_i);
  assign idx_ok     = {1'b0, entry_index_i} < count_q;
  assign del_last   = {1'b0, entry_index_i} == (count_q - hmq_pkg::CNT_W'(1));
  assign is_full    = count_q == hmq_pkg::CNT_W'(hmq_pkg::HEAP_DEPTH);
  assign is_empty   = count_q == '0;
  assign parent_pos = (pos_q - hmq_pkg::ADDR_W'(1)) >> 1;
  assign left_pos   = {1'b0, pos_q, 1'b1};
  assign right_pos  = left_pos + hmq_pkg::CHILD_W'(1);
  assign count_ext  = {1'b0, count_q};
  assign has_left   = left_pos < count_ext;
  assign has_right  = right_pos < count_ext;

  // shared signed comparator, operands chosen by state
  always_comb begin
    cmp_a = key_q;
    cmp_b = rd_data;
    unique case (state_q)
      hmq_pkg::S_DN_R: begin
        cmp_a = rd_data;
        cmp_b = child_q;
      end
      hmq_pkg::S_DN_CMP: begin
        cmp_a = child_q;
        cmp_b = key_q;
      end
      hmq_pkg::S_CHG_USE: begin
        cmp_a = rd_data;
        cmp_b = key_q;
      end
      hmq_pkg::S_DEL_USE: begin
        cmp_a = old_q;
        cmp_b = rd_data;
      end
      default: begin
        cmp_a = key_q;
        cmp_b = rd_data;
      end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hmq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            hmq_pkg::OP_INSERT:  state_d = is_full ? hmq_pkg::S_DONE : hmq_pkg::S_UP_CHK;
            hmq_pkg::OP_EXTRACT: begin
              if (is_empty || (count_q == hmq_pkg::CNT_W'(1))) begin
                state_d = hmq_pkg::S_DONE;
              end else begin
                state_d = hmq_pkg::S_EXT_RD;
              end
            end
            hmq_pkg::OP_CHANGE:  state_d = idx_ok ? hmq_pkg::S_CHG_RD : hmq_pkg::S_DONE;
            hmq_pkg::OP_DELETE: begin
              if (!idx_ok || del_last) begin
                state_d = hmq_pkg::S_DONE;
              end else begin
                state_d = hmq_pkg::S_DEL_RD1;
              end
            end
            default: state_d = hmq_pkg::S_DONE;
          endcase
        end
      end
      hmq_pkg::S_EXT_RD:  state_d = hmq_pkg::S_EXT_USE;
      hmq_pkg::S_EXT_USE: state_d = hmq_pkg::S_DN_CHK;
      hmq_pkg::S_CHG_RD:  state_d = hmq_pkg::S_CHG_USE;
      hmq_pkg::S_CHG_USE: state_d = cmp_lt ? hmq_pkg::S_DN_CHK : hmq_pkg::S_UP_CHK;
      hmq_pkg::S_DEL_RD1: state_d = hmq_pkg::S_DEL_RD2;
      hmq_pkg::S_DEL_RD2: state_d = hmq_pkg::S_DEL_USE;
      hmq_pkg::S_DEL_USE: state_d = cmp_lt ? hmq_pkg::S_DN_CHK : hmq_pkg::S_UP_CHK;
      hmq_pkg::S_UP_CHK:  state_d = (pos_q == '0) ? hmq_pkg::S_DONE : hmq_pkg::S_UP_CMP;
      hmq_pkg::S_UP_CMP:  state_d = cmp_lt ? hmq_pkg::S_UP_CHK : hmq_pkg::S_DONE;
      hmq_pkg::S_DN_CHK:  state_d = has_left ? hmq_pkg::S_DN_L : hmq_pkg::S_DONE;
      hmq_pkg::S_DN_L:    state_d = has_right ? hmq_pkg::S_DN_R : hmq_pkg::S_DN_CMP;
      hmq_pkg::S_DN_R:    state_d = hmq_pkg::S_DN_CMP;
      hmq_pkg::S_DN_CMP:  state_d = cmp_lt ? hmq_pkg::S_DN_CHK : hmq_pkg::S_DONE;
      hmq_pkg::S_DONE:    state_d = out_ready_i ? hmq_pkg::S_IDLE : hmq_pkg::S_DONE;
      default:            state_d = hmq_pkg::S_IDLE;
    endcase
  end

  // datapath updates and store accesses per state
  always_comb begin
    count_d         = count_q;
    pos_d           = pos_q;
    idx_d           = idx_q;
    child_pos_d     = child_pos_q;
    key_d           = key_q;
    child_d         = child_q;
    old_d           = old_q;
    extracted_d     = extracted_q;
    status_d        = status_q;
    mem_req.we      = 1'b0;
    mem_req.wr_addr = pos_q;
    mem_req.wr_data = key_q;
    mem_req.rd_addr = pos_q;
    unique case (state_q)
      hmq_pkg::S_IDLE: begin
        if (accept) begin
          key_d       = key_value_i;
          idx_d       = entry_index_i;
          pos_d       = entry_index_i;
          status_d    = hmq_pkg::ST_OK;
          extracted_d = '0;
          unique case (op_in)
            hmq_pkg::OP_INSERT: begin
              if (is_full) begin
                status_d = hmq_pkg::ST_FULL;
              end else begin
                pos_d   = count_q[hmq_pkg::ADDR_W-1:0];
                count_d = count_q + hmq_pkg::CNT_W'(1);
              end
            end
            hmq_pkg::OP_EXTRACT: begin
              if (is_empty) begin
                status_d = hmq_pkg::ST_EMPTY;
              end else begin
                extracted_d = root_key;
                pos_d       = '0;
                count_d     = count_q - hmq_pkg::CNT_W'(1);
              end
            end
            hmq_pkg::OP_CHANGE: begin
              if (!idx_ok) begin
                status_d = hmq_pkg::ST_BADIDX;
              end
            end
            hmq_pkg::OP_DELETE: begin
              if (!idx_ok) begin
                status_d = hmq_pkg::ST_BADIDX;
              end else begin
                count_d = count_q - hmq_pkg::CNT_W'(1);
              end
            end
            default: status_d = hmq_pkg::ST_OK;
          endcase
        end
      end
      // fetch the last key for the root
      hmq_pkg::S_EXT_RD: begin
        mem_req.rd_addr = count_q[hmq_pkg::ADDR_W-1:0];
      end
      hmq_pkg::S_EXT_USE: begin
        key_d = rd_data;
      end
      // fetch the old key of the slot
      hmq_pkg::S_CHG_RD: begin
        mem_req.rd_addr = idx_q;
      end
      hmq_pkg::S_CHG_USE: begin
        pos_d = idx_q;
      end
      // fetch old key, then the last key moved into the slot
      hmq_pkg::S_DEL_RD1: begin
        mem_req.rd_addr = idx_q;
      end
      hmq_pkg::S_DEL_RD2: begin
        mem_req.rd_addr = count_q[hmq_pkg::ADDR_W-1:0];
        old_d           = rd_data;
      end
      hmq_pkg::S_DEL_USE: begin
        key_d = rd_data;
        pos_d = idx_q;
      end
      // sift up: the moving key stays in a register, parents slide down
      hmq_pkg::S_UP_CHK: begin
        if (pos_q == '0) begin
          mem_req.we = 1'b1;
        end else begin
          mem_req.rd_addr = parent_pos;
        end
      end
      hmq_pkg::S_UP_CMP: begin
        mem_req.we = 1'b1;
        if (cmp_lt) begin
          mem_req.wr_data = rd_data;
          pos_d           = parent_pos;
        end
      end
      // sift down: smaller child, left on a tie, rises into the hole
      hmq_pkg::S_DN_CHK: begin
        if (has_left) begin
          mem_req.rd_addr = left_pos[hmq_pkg::ADDR_W-1:0];
        end else begin
          mem_req.we = 1'b1;
        end
      end
      hmq_pkg::S_DN_L: begin
        child_d     = rd_data;
        child_pos_d = left_pos[hmq_pkg::ADDR_W-1:0];
        mem_req.rd_addr = right_pos[hmq_pkg::ADDR_W-1:0];
      end
      hmq_pkg::S_DN_R: begin
        if (cmp_lt) begin
          child_d     = rd_data;
          child_pos_d = right_pos[hmq_pkg::ADDR_W-1:0];
        end
      end
      hmq_pkg::S_DN_CMP: begin
        mem_req.we = 1'b1;
        if (cmp_lt) begin
          mem_req.wr_data = child_q;
          pos_d           = child_pos_q;
        end
      end
      hmq_pkg::S_DONE: begin
        mem_req.we = 1'b0;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmq_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    idx_q       <= idx_d;
    child_pos_q <= child_pos_d;
    key_q       <= key_d;
    child_q     <= child_d;
    old_q       <= old_d;
    extracted_q <= extracted_d;
    status_q    <= status_d;
  end

  // handshake and result
  assign in_ready_o      = state_q == hmq_pkg::S_IDLE;
  assign out_valid_o     = state_q == hmq_pkg::S_DONE;
  assign status_o        = status_q;
  assign extracted_key_o = extracted_q;
  assign min_key_o       = (count_q == '0) ? '0 : root_key;
  assign entry_count_o   = count_q;

endmodule
